// ===== design/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg
// shared types and constants of the point-in-polygon test unit
// ----------------------------------------------------------------------------
package pip_pkg;

  // default sizing
  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_COORD_WIDTH  = 16;

  // fixed field widths
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 7;

  // input mode codes
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ANSWERED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_STORED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 2'd3;

  // classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

endpackage

// ===== design/pip_ram.sv =====
// ----------------------------------------------------------------------------
// pip_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/pip_front.sv =====
// ----------------------------------------------------------------------------
// pip_front
// accepts items, classifies the mode and queues them for the back end
// ----------------------------------------------------------------------------
module pip_front #(
  parameter int COORD_WIDTH = pip_pkg::DEF_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [pip_pkg::MODE_W-1:0]    in_mode,
  input  logic signed [COORD_WIDTH-1:0] in_coord_x,
  input  logic signed [COORD_WIDTH-1:0] in_coord_y,
  output logic                          q_valid,
  input  logic                          q_pop,
  output pip_pkg::op_t                  q_op,
  output logic signed [COORD_WIDTH-1:0] q_x,
  output logic signed [COORD_WIDTH-1:0] q_y
);
  import pip_pkg::*;

  localparam int QDEPTH = 2;

  op_t                          q_op_r [QDEPTH];
  logic signed [COORD_WIDTH-1:0] q_x_r [QDEPTH];
  logic signed [COORD_WIDTH-1:0] q_y_r [QDEPTH];
  logic                         wr_ptr_r, wr_ptr_nxt;
  logic                         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]                   cnt_r, cnt_nxt;
  logic                         accept;
  logic                         push;
  logic                         pop;
  op_t                          op_cls;

  // classify the mode; the unused code is dropped
  always_comb begin
    op_cls = OP_APPEND;
    push   = 1'b0;
    accept = start && !busy;
    unique case (in_mode)
      MODE_APPEND: begin
        op_cls = OP_APPEND;
        push   = accept;
      end
      MODE_QUERY: begin
        op_cls = OP_QUERY;
        push   = accept;
      end
      MODE_CLEAR: begin
        op_cls = OP_CLEAR;
        push   = accept;
      end
      default: begin
        op_cls = OP_APPEND;
        push   = 1'b0;
      end
    endcase
  end

  assign busy = (cnt_r == 2'd2);
  assign pop  = q_pop && (cnt_r != 2'd0);

  // queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      q_op_r[wr_ptr_r] <= op_cls;
      q_x_r[wr_ptr_r]  <= in_coord_x;
      q_y_r[wr_ptr_r]  <= in_coord_y;
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_op    = q_op_r[rd_ptr_r];
  assign q_x     = q_x_r[rd_ptr_r];
  assign q_y     = q_y_r[rd_ptr_r];

endmodule

// ===== design/pip_back.sv =====
// ----------------------------------------------------------------------------
// pip_back
// executes queued items: vertex append, clear, and the edge-walking query
// ----------------------------------------------------------------------------
module pip_back #(
  parameter int MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES,
  parameter int COORD_WIDTH  = pip_pkg::DEF_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  pip_pkg::op_t                  q_op,
  input  logic signed [COORD_WIDTH-1:0] q_x,
  input  logic signed [COORD_WIDTH-1:0] q_y,
  output logic                          out_strobe,
  output logic                          out_inside_res,
  output logic [pip_pkg::STATUS_W-1:0]  out_status,
  output logic [pip_pkg::TOTAL_W-1:0]   out_vertex_total
);
  import pip_pkg::*;

  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int DW    = COORD_WIDTH + 1;
  localparam int PW    = 2 * DW;
  localparam int VW    = 2 * COORD_WIDTH;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VERTICES);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_WALK  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t                       state_r, state_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [CNT_W-1:0]             issue_r, issue_nxt;
  logic                         parity_r, parity_nxt;
  logic signed [COORD_WIDTH-1:0] px_r, px_nxt;
  logic signed [COORD_WIDTH-1:0] py_r, py_nxt;

  // result registers
  logic                         strobe_r, strobe_nxt;
  logic                         inside_r, inside_nxt;
  logic [STATUS_W-1:0]          status_r, status_nxt;
  logic [CNT_W-1:0]             total_r, total_nxt;
  logic [CNT_W+TOTAL_W-1:0]     total_wide;

  // vertex store ports
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [VW-1:0]                ram_rdata;
  logic [CNT_W-1:0]             count_m1;
  logic [CNT_W-1:0]             issue_m1;

  // walk pipeline
  logic                         iss_v_r, iss_v_nxt;
  logic                         iss_edge_r, iss_edge_nxt;
  logic signed [COORD_WIDTH-1:0] prev_x_r, prev_y_r;
  logic signed [COORD_WIDTH-1:0] cur_x, cur_y;
  logic                         s1_v_r;
  logic signed [DW-1:0]         s1_a_r, s1_d_r, s1_c_r, s1_b_r;
  logic                         s1_cross_r;
  logic                         s2_v_r;
  logic signed [PW-1:0]         s2_p1_r, s2_p2_r;
  logic                         s2_dpos_r;
  logic                         s2_cross_r;
  logic                         toggle;

  pip_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_VERTICES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({q_x, q_y}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign count_m1 = count_r - 1'b1;
  assign issue_m1 = issue_r - 1'b1;
  assign cur_x    = ram_rdata[VW-1:COORD_WIDTH];
  assign cur_y    = ram_rdata[COORD_WIDTH-1:0];

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    issue_nxt    = issue_r;
    parity_nxt   = parity_r;
    px_nxt       = px_r;
    py_nxt       = py_r;
    strobe_nxt   = 1'b0;
    inside_nxt   = inside_r;
    status_nxt   = status_r;
    total_nxt    = total_r;
    q_pop        = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = count_r[AW-1:0];
    ram_re       = 1'b0;
    ram_raddr    = count_m1[AW-1:0];
    iss_v_nxt    = 1'b0;
    iss_edge_nxt = 1'b0;
    if (toggle) begin
      parity_nxt = ~parity_r;
    end
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_op)
            OP_APPEND: begin
              strobe_nxt = 1'b1;
              inside_nxt = 1'b0;
              if (count_r < MAX_CNT) begin
                ram_we     = 1'b1;
                count_nxt  = count_r + 1'b1;
                status_nxt = ST_STORED;
              end else begin
                status_nxt = ST_DROPPED;
              end
              total_nxt = count_nxt;
            end
            OP_CLEAR: begin
              strobe_nxt = 1'b1;
              inside_nxt = 1'b0;
              count_nxt  = '0;
              parity_nxt = 1'b0;
              status_nxt = ST_CLEARED;
              total_nxt  = '0;
            end
            OP_QUERY: begin
              parity_nxt = 1'b0;
              if (count_r == '0) begin
                strobe_nxt = 1'b1;
                inside_nxt = 1'b0;
                status_nxt = ST_ANSWERED;
                total_nxt  = count_r;
              end else begin
                px_nxt    = q_x;
                py_nxt    = q_y;
                issue_nxt = '0;
                state_nxt = S_WALK;
              end
            end
            default: begin
              strobe_nxt = 1'b0;
            end
          endcase
        end
      end
      S_WALK: begin
        // read the last vertex first, then vertices 0 to n-1
        ram_re       = 1'b1;
        ram_raddr    = (issue_r == '0) ? count_m1[AW-1:0] : issue_m1[AW-1:0];
        iss_v_nxt    = 1'b1;
        iss_edge_nxt = (issue_r != '0);
        issue_nxt    = issue_r + 1'b1;
        if (issue_r == count_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!iss_v_r && !s1_v_r && !s2_v_r) begin
          strobe_nxt = 1'b1;
          inside_nxt = parity_r;
          status_nxt = ST_ANSWERED;
          total_nxt  = count_r;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      parity_r <= 1'b0;
      strobe_r <= 1'b0;
      iss_v_r  <= 1'b0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      parity_r <= parity_nxt;
      strobe_r <= strobe_nxt;
      iss_v_r  <= iss_v_nxt;
      s1_v_r   <= iss_v_r && iss_edge_r;
      s2_v_r   <= s1_v_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    issue_r    <= issue_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    inside_r   <= inside_nxt;
    status_r   <= status_nxt;
    total_r    <= total_nxt;
    iss_edge_r <= iss_edge_nxt;
  end

  // stage 1: keep previous vertex, form the edge differences
  always_ff @(posedge clk) begin
    if (iss_v_r) begin
      prev_x_r <= cur_x;
      prev_y_r <= cur_y;
    end
    s1_a_r     <= DW'(px_r) - DW'(cur_x);
    s1_d_r     <= DW'(prev_y_r) - DW'(cur_y);
    s1_c_r     <= DW'(prev_x_r) - DW'(cur_x);
    s1_b_r     <= DW'(py_r) - DW'(cur_y);
    s1_cross_r <= (cur_y > py_r) != (prev_y_r > py_r);
  end

  // stage 2: both cross products
  always_ff @(posedge clk) begin
    s2_p1_r    <= PW'(s1_a_r) * PW'(s1_d_r);
    s2_p2_r    <= PW'(s1_c_r) * PW'(s1_b_r);
    s2_dpos_r  <= !s1_d_r[DW-1];
    s2_cross_r <= s1_cross_r;
  end

  // stage 3: sign-adjusted compare decides the toggle
  assign toggle = s2_v_r && s2_cross_r &&
                  ((s2_dpos_r && (s2_p1_r < s2_p2_r)) ||
                   (!s2_dpos_r && (s2_p1_r > s2_p2_r)));

  assign total_wide       = (CNT_W + TOTAL_W)'(total_r);
  assign out_strobe       = strobe_r;
  assign out_inside_res   = inside_r;
  assign out_status       = status_r;
  assign out_vertex_total = total_wide[TOTAL_W-1:0];

endmodule

// ===== design/point_in_polygon_test_unit.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_test_unit
// even-odd point-in-polygon test over an appendable vertex store
// ----------------------------------------------------------------------------
// Items are taken when start is high and busy is low; a two-entry queue sits
// between the front end and the execution unit, so busy rises only when both
// entries are waiting. Every item except the unused mode code yields exactly
// one result, shown for one cycle with out_strobe high; the receiver cannot
// stall it. Append and clear finish once the execution unit pops them from the
// queue, with the result registered; a query ahead of them can hold them. A
// query walks the stored edges through the vertex ram, one read a cycle, through
// the single ram read port and a three-stage difference, multiply and compare
// pipeline. There is no clearing pass after reset.
module point_in_polygon_test_unit #(
  parameter int MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES,
  parameter int COORD_WIDTH  = pip_pkg::DEF_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [pip_pkg::MODE_W-1:0]    in_mode,
  input  logic signed [COORD_WIDTH-1:0] in_coord_x,
  input  logic signed [COORD_WIDTH-1:0] in_coord_y,
  output logic                          out_strobe,
  output logic                          out_inside_res,
  output logic [pip_pkg::STATUS_W-1:0]  out_status,
  output logic [pip_pkg::TOTAL_W-1:0]   out_vertex_total
);
  import pip_pkg::*;

  logic                          q_valid;
  logic                          q_pop;
  op_t                           q_op;
  logic signed [COORD_WIDTH-1:0] q_x;
  logic signed [COORD_WIDTH-1:0] q_y;

  // front end: accept and classify
  pip_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_mode    (in_mode),
    .in_coord_x (in_coord_x),
    .in_coord_y (in_coord_y),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_op       (q_op),
    .q_x        (q_x),
    .q_y        (q_y)
  );

  // back end: store, clear and query
  pip_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_op             (q_op),
    .q_x              (q_x),
    .q_y              (q_y),
    .out_strobe       (out_strobe),
    .out_inside_res   (out_inside_res),
    .out_status       (out_status),
    .out_vertex_total (out_vertex_total)
  );

endmodule
